/* rtl/qcps_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and types of the quadrature counter and speed block.
package qcps_pkg;

    localparam int CountWidth = 32;
    localparam int TimeWidth  = 32;
    localparam int ConstWidth = 24;
    localparam int SpeedWidth = 14;
    localparam int CfgIndexWidth = 2;

    localparam int DivSteps      = ConstWidth;
    localparam int DivCountWidth = $clog2(DivSteps + 1);

    localparam logic [1:0] ACT_EDGE    = 2'd0;
    localparam logic [1:0] ACT_TIMEOUT = 2'd1;
    localparam logic [1:0] ACT_CLEAR   = 2'd2;

    localparam logic [CfgIndexWidth-1:0] CFG_SPEED_CONSTANT = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_INVERT_LEFT    = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_INVERT_RIGHT   = 2'd2;

    localparam logic [TimeWidth-1:0]  EDGE_MIN_INTERVAL    = 32'd3000;
    localparam logic [TimeWidth-1:0]  VOID_MARGIN          = 32'd10;
    localparam logic [ConstWidth-1:0] SPEED_LIMIT          = 24'd8191;
    localparam logic [ConstWidth-1:0] SPEED_CONSTANT_RESET = 24'd1000000;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic load_out;
    } qcps_cmd_t;

endpackage

/* rtl/qcps_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for encoder items and result beats.
interface qcps_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic        side;
    logic        pin_a;
    logic        pin_b;
    logic [31:0] now_us;

    modport source (output valid, action, side, pin_a, pin_b, now_us, input ready);
    modport sink (input valid, action, side, pin_a, pin_b, now_us, output ready);
endinterface

interface qcps_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] path_count;
    logic signed [13:0] speed;
    logic               forward;

    modport source (output valid, path_count, speed, forward, input ready);
    modport sink (input valid, path_count, speed, forward, output ready);
endinterface

/* rtl/qcps_ctrl.sv */
`timescale 1ns / 1ps
// Controller: accepts an item, sequences the divider steps and loads the result beat.
module qcps_ctrl
    import qcps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    output logic      result_valid,
    input  logic      result_ready,
    output qcps_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic                     state_reg;
    logic                     state_next;
    logic [DivCountWidth-1:0] step_cnt_reg;
    logic [DivCountWidth-1:0] step_cnt_next;
    logic                     result_valid_reg;
    logic                     result_valid_next;
    logic                     div_done;

    always_comb
    begin
        div_done     = (step_cnt_reg == DivCountWidth'(DivSteps));
        item_ready   = (state_reg == ST_IDLE);
        result_valid = result_valid_reg;

        cmd.accept   = (state_reg == ST_IDLE) && item_valid;
        cmd.div_step = (state_reg == ST_DIV) && !div_done;
        cmd.load_out = (state_reg == ST_DIV) && div_done
                       && (!result_valid_reg || result_ready);

        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next    = ST_DIV;
                    step_cnt_next = '0;
                end
            end
            ST_DIV:
            begin
                if (cmd.div_step)
                begin
                    step_cnt_next = step_cnt_reg + DivCountWidth'(1);
                end
                if (cmd.load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load_out)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_cnt_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_cnt_reg     <= step_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

endmodule

/* rtl/qcps_datapath.sv */
`timescale 1ns / 1ps
// Datapath: configuration, per-wheel encoder state, restoring divider and result registers.
module qcps_datapath
    import qcps_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  qcps_cmd_t                    cmd,
    input  logic                         cfg_we,
    input  logic [CfgIndexWidth-1:0]     cfg_index,
    input  logic [ConstWidth-1:0]        cfg_wdata,
    input  logic [1:0]                   action,
    input  logic                         side,
    input  logic                         pin_a,
    input  logic                         pin_b,
    input  logic [TimeWidth-1:0]         now_us,
    output logic signed [CountWidth-1:0] path_count,
    output logic signed [SpeedWidth-1:0] speed,
    output logic                         forward
);

    logic [ConstWidth-1:0] speed_constant_reg;
    logic                  invert_left_reg;
    logic                  invert_right_reg;

    logic [CountWidth-1:0] edge_count_reg [2];
    logic                  moving_forward_reg [2];
    logic [TimeWidth-1:0]  last_edge_time_reg [2];
    logic                  edge_time_valid_reg [2];
    logic [TimeWidth-1:0]  edge_interval_reg [2];

    logic [CountWidth-1:0] count_next;
    logic                  fwd_next;
    logic [TimeWidth-1:0]  time_next;
    logic                  tvalid_next;
    logic [TimeWidth-1:0]  interval_next;
    logic [TimeWidth-1:0]  elapsed;
    logic                  inv;

    logic [CountWidth-1:0] res_count_reg;
    logic                  res_dir_reg;
    logic [TimeWidth-1:0]  divisor_reg;
    logic [TimeWidth-1:0]  rem_reg;
    logic [ConstWidth-1:0] quo_reg;
    logic [TimeWidth:0]    trial;
    logic [SpeedWidth-1:0] quo_sat;

    logic signed [CountWidth-1:0] path_count_reg;
    logic signed [SpeedWidth-1:0] speed_reg;
    logic                         forward_reg;

    always_comb
    begin
        inv           = side ? invert_right_reg : invert_left_reg;
        elapsed       = now_us - last_edge_time_reg[side];
        count_next    = edge_count_reg[side];
        fwd_next      = moving_forward_reg[side];
        time_next     = last_edge_time_reg[side];
        tvalid_next   = edge_time_valid_reg[side];
        interval_next = edge_interval_reg[side];
        case (action)
            ACT_EDGE:
            begin
                if (pin_a ^ pin_b)
                begin
                    count_next = edge_count_reg[side] + CountWidth'(1);
                    fwd_next   = 1'b1;
                end
                else
                begin
                    count_next = edge_count_reg[side] - CountWidth'(1);
                    fwd_next   = 1'b0;
                end
                if (edge_time_valid_reg[side] && (elapsed > EDGE_MIN_INTERVAL))
                begin
                    interval_next = elapsed;
                end
                time_next   = now_us;
                tvalid_next = 1'b1;
            end
            ACT_TIMEOUT:
            begin
                if (!edge_time_valid_reg[side]
                    || (elapsed > TimeWidth'(speed_constant_reg)))
                begin
                    tvalid_next   = 1'b0;
                    interval_next = TimeWidth'(speed_constant_reg) + VOID_MARGIN;
                end
            end
            ACT_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = edge_count_reg[side];
            end
        endcase

        trial   = {rem_reg, quo_reg[ConstWidth-1]} - {1'b0, divisor_reg};
        quo_sat = (quo_reg > SPEED_LIMIT) ? SpeedWidth'(SPEED_LIMIT)
                                          : quo_reg[SpeedWidth-1:0];

        path_count = path_count_reg;
        speed      = speed_reg;
        forward    = forward_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_constant_reg <= SPEED_CONSTANT_RESET;
            invert_left_reg    <= 1'b0;
            invert_right_reg   <= 1'b0;
            for (int s = 0; s < 2; s++)
            begin
                edge_count_reg[s]      <= '0;
                moving_forward_reg[s]  <= 1'b1;
                last_edge_time_reg[s]  <= '0;
                edge_time_valid_reg[s] <= 1'b0;
                edge_interval_reg[s]   <= TimeWidth'(SPEED_CONSTANT_RESET) + VOID_MARGIN;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SPEED_CONSTANT: speed_constant_reg <= cfg_wdata;
                    CFG_INVERT_LEFT:    invert_left_reg    <= cfg_wdata[0];
                    CFG_INVERT_RIGHT:   invert_right_reg   <= cfg_wdata[0];
                    default:            speed_constant_reg <= speed_constant_reg;
                endcase
            end
            if (cmd.accept)
            begin
                edge_count_reg[side]      <= count_next;
                moving_forward_reg[side]  <= fwd_next;
                last_edge_time_reg[side]  <= time_next;
                edge_time_valid_reg[side] <= tvalid_next;
                edge_interval_reg[side]   <= interval_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            res_count_reg <= inv ? (CountWidth'(0) - count_next) : count_next;
            res_dir_reg   <= fwd_next ^ inv;
            divisor_reg   <= (interval_next == '0) ? TimeWidth'(1) : interval_next;
            rem_reg       <= '0;
            quo_reg       <= speed_constant_reg;
        end
        else if (cmd.div_step)
        begin
            if (!trial[TimeWidth])
            begin
                rem_reg <= trial[TimeWidth-1:0];
                quo_reg <= {quo_reg[ConstWidth-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[TimeWidth-2:0], quo_reg[ConstWidth-1]};
                quo_reg <= {quo_reg[ConstWidth-2:0], 1'b0};
            end
        end

        if (cmd.load_out)
        begin
            path_count_reg <= res_count_reg;
            speed_reg      <= res_dir_reg ? quo_sat : (SpeedWidth'(0) - quo_sat);
            forward_reg    <= res_dir_reg;
        end
    end

endmodule

/* rtl/quadrature_count_and_period_speed.sv */
`timescale 1ns / 1ps
// Top level of the two-wheel quadrature counter with period-based speed.
// Each accepted item updates the addressed wheel's count, direction and edge timing
// in its acceptance cycle, then a restoring divider forms the 24-bit quotient
// speed_constant / interval one bit per cycle; the result beat is then loaded once the
// result register is free or being taken, and the next item can be accepted in the
// cycle after the load. The result register lets the next item enter and divide while
// the previous beat still waits to be taken. Configuration writes take effect at once
// and are expected only while no item is in flight.
module quadrature_count_and_period_speed
    import qcps_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    qcps_item_if.sink                item,
    qcps_result_if.source            result,
    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [ConstWidth-1:0]    cfg_wdata
);

    qcps_cmd_t cmd;

    qcps_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd)
    );

    qcps_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .action     (item.action),
        .side       (item.side),
        .pin_a      (item.pin_a),
        .pin_b      (item.pin_b),
        .now_us     (item.now_us),
        .path_count (result.path_count),
        .speed      (result.speed),
        .forward    (result.forward)
    );

endmodule
